// ----- hw/rtl/dpg_pkg.sv -----
// ----------------------------------------------------------------------------
// dpg_pkg
// Widths, register indexes and stage records for the distance pan gain block.
// ----------------------------------------------------------------------------
package dpg_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int COORD_FRAC     = 12;
  localparam int GAIN_W         = 16;
  localparam int RIGHT_W        = 16;
  localparam int PAN_FRAC       = 14;
  localparam int PAN_ONE        = 1 << PAN_FRAC;
  localparam int PF_W           = PAN_FRAC + 1;
  localparam int QW2            = PAN_FRAC + 1;
  localparam int GAIN_MAX       = (1 << GAIN_W) - 1;

  localparam int DSHIFT    = (COORD_WIDTH > 30) ? (COORD_WIDTH - 30) : 0;
  localparam int DIST_FRAC = COORD_FRAC - DSHIFT;
  localparam int ONE4      = 1 << (DIST_FRAC + 2);
  localparam int PAN_MIN   = (1 << DIST_FRAC) / 1000;

  localparam int DW   = COORD_WIDTH + 1 - DSHIFT;
  localparam int AW   = DW;
  localparam int SQW  = 2 * AW + 2;
  localparam int RW   = AW + 1;
  localparam int DOTW = DW + RIGHT_W + 2;
  localparam int GW   = 2 * GAIN_W - GAIN_FRAC_BITS;
  localparam int DV1W = GW + RW + 1;
  localparam int DV2W = DOTW + RW + 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LISTENER_X = 3'd0,
    CFG_LISTENER_Y = 3'd1,
    CFG_LISTENER_Z = 3'd2,
    CFG_RIGHT_X    = 3'd3,
    CFG_RIGHT_Y    = 3'd4,
    CFG_RIGHT_Z    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic                   v;
    logic [SQW-1:0]         rem;
    logic [RW-1:0]          root;
    logic signed [DOTW-1:0] dot;
    logic [GW-1:0]          g;
    logic                   rel;
  } sqrt_st_t;

  typedef struct packed {
    logic              v;
    logic [DV1W-1:0]   rem1;
    logic [RW:0]       den1;
    logic [GW-1:0]     q1;
    logic [DV2W-1:0]   rem2;
    logic [RW+2:0]     den2;
    logic [QW2-1:0]    q2;
    logic              ovf;
    logic              pan_en;
    logic              neg;
    logic [GW-1:0]     g;
    logic              rel;
  } div_st_t;

  function automatic logic signed [DW-1:0] shrink(input logic signed [COORD_WIDTH:0] d);
    logic [COORD_WIDTH:0] m;
    logic [DW-1:0]        s;
    m = d[COORD_WIDTH] ? ($unsigned(~d) + 1'b1) : $unsigned(d);
    s = DW'(m >> DSHIFT);
    return d[COORD_WIDTH] ? -$signed(s) : $signed(s);
  endfunction

  function automatic logic [AW-1:0] mag_d(input logic signed [DW-1:0] d);
    return d[DW-1] ? ($unsigned(~d) + 1'b1) : $unsigned(d);
  endfunction

endpackage

// ----- hw/rtl/dpg_if.sv -----
// ----------------------------------------------------------------------------
// dpg_if
// Source item and gain result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpg_item_if;
  import dpg_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] src_x;
  logic signed [COORD_WIDTH-1:0] src_y;
  logic signed [COORD_WIDTH-1:0] src_z;
  logic [GAIN_W-1:0]             speaker_volume;
  logic [GAIN_W-1:0]             mixer_volume;
  logic                          is_relative;

  modport source(output valid, src_x, src_y, src_z, speaker_volume, mixer_volume,
                 is_relative, input ready);
  modport sink(input valid, src_x, src_y, src_z, speaker_volume, mixer_volume,
               is_relative, output ready);
endinterface

interface dpg_result_if;
  import dpg_pkg::*;

  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] left_gain;
  logic [GAIN_W-1:0] right_gain;

  modport source(output valid, left_gain, right_gain, input ready);
  modport sink(input valid, left_gain, right_gain, output ready);
endinterface

// ----- hw/rtl/distance_pan_gain.sv -----
// ----------------------------------------------------------------------------
// distance_pan_gain
// Left/right gains from source position, volumes and listener registers.
// ----------------------------------------------------------------------------
// One word enters per cycle unless the output stalls: three stages form the
// offsets, squares and dot product, a bit-per-stage square root gives the
// distance, a bit-per-stage pair of dividers forms attenuation and pan, and
// three stages apply pan and saturate. A stall at the output holds the whole
// pipeline.
module distance_pan_gain (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  dpg_item_if.sink                         item,
  dpg_result_if.source                     result
);
  import dpg_pkg::*;

  logic signed [COORD_WIDTH-1:0] listener_x, listener_y, listener_z;
  logic signed [RIGHT_W-1:0]     right_x, right_y, right_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      listener_x <= '0;
      listener_y <= '0;
      listener_z <= '0;
      right_x    <= RIGHT_W'(PAN_ONE);
      right_y    <= '0;
      right_z    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LISTENER_X: listener_x <= cfg_data[COORD_WIDTH-1:0];
        CFG_LISTENER_Y: listener_y <= cfg_data[COORD_WIDTH-1:0];
        CFG_LISTENER_Z: listener_z <= cfg_data[COORD_WIDTH-1:0];
        CFG_RIGHT_X:    right_x    <= cfg_data[RIGHT_W-1:0];
        CFG_RIGHT_Y:    right_y    <= cfg_data[RIGHT_W-1:0];
        CFG_RIGHT_Z:    right_z    <= cfg_data[RIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v7;
  assign en         = !v7 || result.ready;
  assign item.ready = en;

  // stage 1: offsets and base gain
  logic                    v1, rel1;
  logic signed [DW-1:0]    d1x, d1y, d1z;
  logic [GW-1:0]           g1;
  logic [2*GAIN_W-1:0]     gprod;
  logic signed [COORD_WIDTH:0] dfx, dfy, dfz;

  assign gprod = (2*GAIN_W)'(item.speaker_volume) * (2*GAIN_W)'(item.mixer_volume);
  assign dfx   = {item.src_x[COORD_WIDTH-1], item.src_x}
               - {listener_x[COORD_WIDTH-1], listener_x};
  assign dfy   = {item.src_y[COORD_WIDTH-1], item.src_y}
               - {listener_y[COORD_WIDTH-1], listener_y};
  assign dfz   = {item.src_z[COORD_WIDTH-1], item.src_z}
               - {listener_z[COORD_WIDTH-1], listener_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1   <= item.valid;
      rel1 <= item.is_relative;
      g1   <= gprod[2*GAIN_W-1:GAIN_FRAC_BITS];
      d1x  <= shrink(dfx);
      d1y  <= shrink(dfy);
      d1z  <= shrink(dfz);
    end
  end

  // stage 2: squares and dot terms
  logic                           v2, rel2;
  logic [GW-1:0]                  g2;
  logic [2*AW-1:0]                sqx, sqy, sqz;
  logic signed [DW+RIGHT_W-1:0]   dpx, dpy, dpz;
  logic [AW-1:0]                  ax, ay, az;
  logic signed [DW+RIGHT_W-1:0]   dpx_next, dpy_next, dpz_next;

  assign ax = mag_d(d1x);
  assign ay = mag_d(d1y);
  assign az = mag_d(d1z);
  assign dpx_next = d1x * right_x;
  assign dpy_next = d1y * right_y;
  assign dpz_next = d1z * right_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2   <= v1;
      rel2 <= rel1;
      g2   <= g1;
      sqx  <= (2*AW)'(ax) * (2*AW)'(ax);
      sqy  <= (2*AW)'(ay) * (2*AW)'(ay);
      sqz  <= (2*AW)'(az) * (2*AW)'(az);
      dpx  <= dpx_next;
      dpy  <= dpy_next;
      dpz  <= dpz_next;
    end
  end

  // stage 3: sums, then square root one bit per stage
  sqrt_st_t sqs [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqs[0].v <= 1'b0;
    end else if (en) begin
      sqs[0].v    <= v2;
      sqs[0].rem  <= SQW'(sqx) + SQW'(sqy) + SQW'(sqz);
      sqs[0].root <= '0;
      sqs[0].dot  <= DOTW'(dpx) + DOTW'(dpy) + DOTW'(dpz);
      sqs[0].g    <= g2;
      sqs[0].rel  <= rel2;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    localparam int K = RW - 1 - i;
    logic [SQW:0] trial;
    logic         ge;
    sqrt_st_t     sq_next;
    assign trial = ((SQW+1)'(sqs[i].root) << (K + 1)) + ((SQW+1)'(1) << (2 * K));
    assign ge    = {1'b0, sqs[i].rem} >= trial;

    always_comb begin
      sq_next = sqs[i];
      if (ge) begin
        sq_next.rem  = sqs[i].rem - trial[SQW-1:0];
        sq_next.root = sqs[i].root | (RW'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqs[i+1].v <= 1'b0;
      end else if (en) begin
        sqs[i+1] <= sq_next;
      end
    end
  end

  // divider set-up, then one quotient bit per stage
  div_st_t divs [GW+1];
  logic [RW-1:0]   src_dist;
  logic [DOTW-1:0] dmag;

  assign src_dist = sqs[RW].root;
  assign dmag = sqs[RW].dot[DOTW-1] ? ($unsigned(~sqs[RW].dot) + 1'b1)
                                    : $unsigned(sqs[RW].dot);

  always_ff @(posedge clk) begin
    if (rst) begin
      divs[0].v <= 1'b0;
    end else if (en) begin
      divs[0].v      <= sqs[RW].v;
      divs[0].rem1   <= DV1W'(sqs[RW].g) << (DIST_FRAC + 2);
      divs[0].den1   <= (RW+1)'(ONE4) + (RW+1)'(src_dist);
      divs[0].q1     <= '0;
      divs[0].rem2   <= (DV2W'(dmag) << 1) + DV2W'(dmag);
      divs[0].den2   <= ((RW+3)'(src_dist) << 2) + (RW+3)'(src_dist);
      divs[0].q2     <= '0;
      divs[0].ovf    <= 1'b0;
      divs[0].pan_en <= !sqs[RW].rel && (src_dist > RW'(PAN_MIN));
      divs[0].neg    <= sqs[RW].dot[DOTW-1];
      divs[0].g      <= sqs[RW].g;
      divs[0].rel    <= sqs[RW].rel;
    end
  end

  for (genvar s = 0; s < GW; s++) begin : g_div
    localparam int K = GW - 1 - s;
    logic [DV1W-1:0] t1;
    logic            ge1;
    logic [DV2W-1:0] t2;
    logic            ge2;
    div_st_t         div_next;
    assign t1  = DV1W'(divs[s].den1) << K;
    assign ge1 = divs[s].rem1 >= t1;
    if (K < QW2) begin : g_pan
      assign t2  = DV2W'(divs[s].den2) << K;
      assign ge2 = divs[s].rem2 >= t2;
    end else if (s == 0) begin : g_ovf
      assign t2  = DV2W'(divs[s].den2) << QW2;
      assign ge2 = divs[s].rem2 >= t2;
    end else begin : g_idle
      assign t2  = '0;
      assign ge2 = 1'b0;
    end

    always_comb begin
      div_next = divs[s];
      if (ge1) begin
        div_next.rem1 = divs[s].rem1 - t1;
        div_next.q1   = divs[s].q1 | (GW'(1) << K);
      end
      if (K < QW2) begin
        if (ge2) begin
          div_next.rem2 = divs[s].rem2 - t2;
          div_next.q2   = divs[s].q2 | (QW2'(1) << K);
        end
      end else if (s == 0) begin
        div_next.ovf = ge2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        divs[s+1].v <= 1'b0;
      end else if (en) begin
        divs[s+1] <= div_next;
      end
    end
  end

  // pan factors
  logic              v5, rel5;
  logic [GW-1:0]     g5;
  logic [PF_W-1:0]   lf5, rf5;
  logic [PF_W-1:0]   pmag;
  logic [PF_W-1:0]   pan_lf, pan_rf;

  always_comb begin
    pmag = '0;
    if (divs[GW].pan_en) begin
      if (divs[GW].ovf || divs[GW].q2 > QW2'(PAN_ONE)) begin
        pmag = PF_W'(PAN_ONE);
      end else begin
        pmag = PF_W'(divs[GW].q2);
      end
    end
    pan_lf = divs[GW].neg ? PF_W'(PAN_ONE) : PF_W'(PAN_ONE) - pmag;
    pan_rf = divs[GW].neg ? PF_W'(PAN_ONE) - pmag : PF_W'(PAN_ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5   <= divs[GW].v;
      rel5 <= divs[GW].rel;
      g5   <= divs[GW].rel ? divs[GW].g : divs[GW].q1;
      lf5  <= pan_lf;
      rf5  <= pan_rf;
    end
  end

  // apply pan
  logic                 v6, rel6;
  logic [GW+PF_W-1:0]   pl6, pr6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6   <= v5;
      rel6 <= rel5;
      pl6  <= (GW+PF_W)'(g5) * (GW+PF_W)'(lf5);
      pr6  <= (GW+PF_W)'(g5) * (GW+PF_W)'(rf5);
    end
  end

  // saturate into the output register
  logic                  rel7;
  logic [GAIN_W-1:0]     l7, r7;
  logic [GW+PF_W-PAN_FRAC-1:0] lsh, rsh;

  assign lsh = pl6[GW+PF_W-1:PAN_FRAC];
  assign rsh = pr6[GW+PF_W-1:PAN_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7   <= v6;
      rel7 <= rel6;
      l7   <= (lsh > (GW+PF_W-PAN_FRAC)'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX)
                                                    : lsh[GAIN_W-1:0];
      r7   <= (rsh > (GW+PF_W-PAN_FRAC)'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX)
                                                    : rsh[GAIN_W-1:0];
    end
  end

  assign result.valid      = v7;
  assign result.left_gain  = l7;
  assign result.right_gain = r7;

`ifndef SYNTH
  a_rel_equal: assert property (@(posedge clk) disable iff (rst)
    result.valid && rel7 |-> result.left_gain == result.right_gain)
    else $error("relative word with unequal gains");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (lf5 == PF_W'(PAN_ONE)) || (rf5 == PF_W'(PAN_ONE)))
    else $error("pan lowers both sides");

  a_rel_nopan: assert property (@(posedge clk) disable iff (rst)
    v5 && rel5 |-> (lf5 == PF_W'(PAN_ONE)) && (rf5 == PF_W'(PAN_ONE)))
    else $error("relative word panned");
`endif

endmodule
